// File: hw/rtl/kcd_pkg.sv
// Shared types and constants for the Kahn cycle detector.
package kcd_pkg;

    // Field widths fixed by the stream format
    localparam int VTX_W   = 6;
    localparam int COUNT_W = 7;
    localparam int FLAGS_W = 2;

    // Register map and reset value
    localparam logic [1:0]         REG_VERTEX_COUNT = 2'd0;
    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

    // Status flag bit positions
    localparam int ERR_RANGE    = 0;
    localparam int ERR_OVERFLOW = 1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;           // input beat accepted
        logic walk_init;      // zero walk counters
        logic clr_wr;         // write zero in-degree at vertex index
        logic vidx_clr;       // rewind vertex index
        logic vidx_inc;       // advance vertex index
        logic deg_sel_vertex; // in-degree read address from vertex index
        logic e_inc;          // advance edge index
        logic deg_inc_wr;     // write in-degree + 1 at edge target
        logic deg_dec_wr;     // write in-degree - 1 at edge target
        logic push_vertex;    // queue the vertex index
        logic push_dst;       // queue the edge target
        logic take_top;       // latch dequeued vertex, count it
        logic finish;         // load result, clear graph state
    } kcd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic edge_end;    // edge index reached edges loaded
        logic edge_ok;     // read edge lies inside the vertex range
        logic match;       // read edge leaves the current vertex
        logic deg_zero;    // read in-degree is zero
        logic deg_one;     // read in-degree is one
        logic vertex_end;  // vertex index reached vertex count
        logic queue_empty; // ready queue drained
        logic out_free;    // result register can take a new beat
    } kcd_stat_t;

endpackage

// File: hw/rtl/kahn_cycle_detect.sv
// Sequence: edge beats are accepted while loading; a tlast beat starts the walk, which clears
// the in-degrees, counts them over the stored edges, queues the zero in-degree vertices, then per
// dequeued vertex releases its out-edges, and after an empty check loads the result beat.
// Throughput: one edge beat per cycle while loading; s_tready is low for the whole walk,
// which ends later while an earlier result beat waits for m_tready.
// Reset: aresetn is synchronous, active low; vertex_count returns to 64, counters clear.
module kahn_cycle_detect
    import kcd_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Edge stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] from_vertex, [11:6] to_vertex, [15:12] zero
    input  logic        s_tuser,   // [0] edge_valid
    input  logic        s_tlast,   // last_edge
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] has_cycle, [7:1] ordered_count, [9:8] status
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [COUNT_W-1:0] vertex_count_reg;
    kcd_cmd_t           cmd;
    kcd_stat_t          stat;

    // Single register at word zero; byte offset bits are ignored.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= VERTEX_COUNT_RST;
        end else if (psel && penable && pwrite && pready) begin
            vertex_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Hold read data on the one register regardless of offset.
    always_comb begin
        prdata = '0;
        case (paddr & ~2'b11)
            REG_VERTEX_COUNT: prdata = {25'b0, vertex_count_reg};
            default:          prdata = '0;
        endcase
    end

    // Sequence loading and the walk
    kcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store edges, track in-degrees, drain the ready queue
    kcd_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .vertex_count (vertex_count_reg),
        .from_vertex  (s_tdata[5:0]),
        .to_vertex    (s_tdata[11:6]),
        .edge_valid   (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// File: hw/rtl/kcd_ctrl.sv
// Sequencer for edge loading and the Kahn walk.
module kcd_ctrl
    import kcd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    input  kcd_stat_t stat,
    output kcd_cmd_t  cmd
);

    typedef enum logic [12:0] {
        S_LOAD    = 13'b0000000000001,
        S_CLR     = 13'b0000000000010,
        S_CNT_RD  = 13'b0000000000100,
        S_CNT_IDX = 13'b0000000001000,
        S_CNT_WR  = 13'b0000000010000,
        S_SCAN_RD = 13'b0000000100000,
        S_SCAN_CK = 13'b0000001000000,
        S_POP     = 13'b0000010000000,
        S_TOP     = 13'b0000100000000,
        S_REL_RD  = 13'b0001000000000,
        S_REL_IDX = 13'b0010000000000,
        S_REL_WR  = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_LOAD);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        cmd.walk_init = 1'b1;
                        state_next    = S_CLR;
                    end
                end
            end
            S_CLR: begin
                cmd.deg_sel_vertex = 1'b1;
                if (stat.vertex_end) begin
                    state_next = S_CNT_RD;
                end else begin
                    cmd.clr_wr   = 1'b1;
                    cmd.vidx_inc = 1'b1;
                end
            end
            S_CNT_RD: begin
                if (stat.edge_end) begin
                    cmd.vidx_clr = 1'b1;
                    state_next   = S_SCAN_RD;
                end else begin
                    state_next = S_CNT_IDX;
                end
            end
            S_CNT_IDX: begin
                if (stat.edge_ok) begin
                    state_next = S_CNT_WR;
                end else begin
                    cmd.e_inc  = 1'b1;
                    state_next = S_CNT_RD;
                end
            end
            S_CNT_WR: begin
                cmd.deg_inc_wr = 1'b1;
                cmd.e_inc      = 1'b1;
                state_next     = S_CNT_RD;
            end
            S_SCAN_RD: begin
                cmd.deg_sel_vertex = 1'b1;
                state_next = stat.vertex_end ? S_POP : S_SCAN_CK;
            end
            S_SCAN_CK: begin
                cmd.push_vertex = stat.deg_zero;
                cmd.vidx_inc    = 1'b1;
                state_next      = S_SCAN_RD;
            end
            S_POP: begin
                state_next = stat.queue_empty ? S_DONE : S_TOP;
            end
            S_TOP: begin
                cmd.take_top = 1'b1;
                state_next   = S_REL_RD;
            end
            S_REL_RD: begin
                state_next = stat.edge_end ? S_POP : S_REL_IDX;
            end
            S_REL_IDX: begin
                if (stat.match) begin
                    state_next = S_REL_WR;
                end else begin
                    cmd.e_inc  = 1'b1;
                    state_next = S_REL_RD;
                end
            end
            S_REL_WR: begin
                cmd.deg_dec_wr = !stat.deg_zero;
                cmd.push_dst   = stat.deg_one;
                cmd.e_inc      = 1'b1;
                state_next     = S_REL_RD;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// File: hw/rtl/kcd_datapath.sv
// Edge, in-degree and queue memories with walk counters and result register.
module kcd_datapath
    import kcd_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  kcd_cmd_t           cmd,
    output kcd_stat_t          stat,
    input  logic [COUNT_W-1:0] vertex_count,
    input  logic [VTX_W-1:0]   from_vertex,
    input  logic [VTX_W-1:0]   to_vertex,
    input  logic               edge_valid,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata
);

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int VCW  = $clog2(MAX_VERTICES + 1);
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int CMPW = (VCW > VTX_W) ? VCW : VTX_W;

    // Memories
    logic [VTX_W-1:0] src_mem [MAX_EDGES];
    logic [VTX_W-1:0] dst_mem [MAX_EDGES];
    logic [ECW-1:0]   deg_mem [MAX_VERTICES];
    logic [VW-1:0]    q_mem   [MAX_VERTICES];

    logic [VTX_W-1:0] edge_src_q, edge_dst_q;
    logic [ECW-1:0]   deg_q;
    logic [VW-1:0]    q_q;

    // Counters
    logic [ECW-1:0]     edges_loaded_reg, edges_loaded_next;
    logic [FLAGS_W-1:0] err_reg, err_next;
    logic [ECW-1:0]     e_reg;
    logic [VCW-1:0]     vidx_reg, head_reg, tail_reg, removed_reg;
    logic [VW-1:0]      top_reg;

    logic               m_valid_reg;
    logic [15:0]        m_data_reg;

    logic [VCW-1:0]     nv;
    logic               in_range, edge_wr, can_push;
    logic [VW-1:0]      deg_raddr, deg_waddr;
    logic [ECW-1:0]     deg_wdata;
    logic               deg_we, q_we;
    logic [VW-1:0]      q_wdata;

    assign nv = (int'(vertex_count) > MAX_VERTICES) ? VCW'(MAX_VERTICES) : VCW'(vertex_count);

    // Load checks
    assign in_range = (CMPW'(from_vertex) < CMPW'(nv)) && (CMPW'(to_vertex) < CMPW'(nv));
    assign edge_wr  = cmd.load && edge_valid && in_range
                      && (edges_loaded_reg != ECW'(MAX_EDGES));

    always_comb begin
        edges_loaded_next = edges_loaded_reg;
        err_next          = err_reg;
        if (cmd.finish) begin
            edges_loaded_next = '0;
            err_next          = '0;
        end else if (cmd.load && edge_valid) begin
            if (!in_range) begin
                err_next[ERR_RANGE] = 1'b1;
            end else if (edges_loaded_reg == ECW'(MAX_EDGES)) begin
                err_next[ERR_OVERFLOW] = 1'b1;
            end else begin
                edges_loaded_next = edges_loaded_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (edge_wr) begin
            src_mem[edges_loaded_reg[EAW-1:0]] <= from_vertex;
            dst_mem[edges_loaded_reg[EAW-1:0]] <= to_vertex;
        end
        edge_src_q <= src_mem[e_reg[EAW-1:0]];
        edge_dst_q <= dst_mem[e_reg[EAW-1:0]];
    end

    // In-degree store
    assign deg_raddr = cmd.deg_sel_vertex ? vidx_reg[VW-1:0] : VW'(edge_dst_q);
    assign deg_waddr = cmd.clr_wr ? vidx_reg[VW-1:0] : VW'(edge_dst_q);
    assign deg_we    = cmd.clr_wr || cmd.deg_inc_wr || cmd.deg_dec_wr;

    always_comb begin
        deg_wdata = '0;
        if (cmd.deg_inc_wr) begin
            deg_wdata = deg_q + 1'b1;
        end else if (cmd.deg_dec_wr) begin
            deg_wdata = deg_q - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (deg_we) begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        deg_q <= deg_mem[deg_raddr];
    end

    // Ready queue
    assign can_push = (tail_reg < VCW'(MAX_VERTICES));
    assign q_we     = (cmd.push_vertex || cmd.push_dst) && can_push;
    assign q_wdata  = cmd.push_vertex ? vidx_reg[VW-1:0] : VW'(edge_dst_q);

    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[tail_reg[VW-1:0]] <= q_wdata;
        end
        q_q <= q_mem[head_reg[VW-1:0]];
    end

    // Walk counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edges_loaded_reg <= '0;
            err_reg          <= '0;
            e_reg            <= '0;
            vidx_reg         <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            removed_reg      <= '0;
            top_reg          <= '0;
        end else begin
            edges_loaded_reg <= edges_loaded_next;
            err_reg          <= err_next;
            if (cmd.walk_init) begin
                e_reg       <= '0;
                vidx_reg    <= '0;
                head_reg    <= '0;
                tail_reg    <= '0;
                removed_reg <= '0;
            end else begin
                if (cmd.take_top) begin
                    e_reg <= '0;
                end else if (cmd.e_inc) begin
                    e_reg <= e_reg + 1'b1;
                end
                if (cmd.vidx_clr) begin
                    vidx_reg <= '0;
                end else if (cmd.vidx_inc) begin
                    vidx_reg <= vidx_reg + 1'b1;
                end
                if (cmd.take_top) begin
                    top_reg     <= q_q;
                    head_reg    <= head_reg + 1'b1;
                    removed_reg <= removed_reg + 1'b1;
                end
                if (q_we) begin
                    tail_reg <= tail_reg + 1'b1;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_data_reg <= {6'b0, err_reg, COUNT_W'(removed_reg), (removed_reg < nv)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Status
    always_comb begin
        stat.edge_end    = (e_reg == edges_loaded_reg);
        stat.edge_ok     = (CMPW'(edge_src_q) < CMPW'(nv)) && (CMPW'(edge_dst_q) < CMPW'(nv));
        stat.match       = stat.edge_ok && (CMPW'(edge_src_q) == CMPW'(top_reg));
        stat.deg_zero    = (deg_q == '0);
        stat.deg_one     = (deg_q == ECW'(1));
        stat.vertex_end  = (vidx_reg == nv);
        stat.queue_empty = (head_reg == tail_reg);
        stat.out_free    = !m_valid_reg || m_tready;
    end

`ifndef SYNTHESIS
    a_head_le_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= tail_reg)
        else $error("queue head passed tail");
    a_tail_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg <= VCW'(MAX_VERTICES))
        else $error("queue tail beyond depth");
    a_edges_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        edges_loaded_reg <= ECW'(MAX_EDGES))
        else $error("edge count beyond capacity");
    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (edges_loaded_reg == '0) && (err_reg == '0) && m_valid_reg)
        else $error("graph state not cleared after result");
`endif

endmodule
